FILE: rtl/gsm_pkg.sv
// shared constants for the golden-section minimizer
`timescale 1ns / 1ps

package gsm_pkg;

   // fixed port field widths
   localparam int FIELD_WIDTH = 32;
   localparam int TOL_WIDTH   = 31;
   localparam int KIND_WIDTH  = 2;
   localparam int PHASE_WIDTH = 3;

   // default position width, signed fixed point
   localparam int POS_WIDTH_DEFAULT = 32;

   // 1/phi as an unsigned fraction
   localparam int                    INV_PHI_BITS = 16;
   localparam logic [INV_PHI_BITS-1:0] INV_PHI    = 16'd40503;

   localparam logic [TOL_WIDTH-1:0] TOL_RESET = 31'd66;

   // request op codes
   localparam logic OP_START = 1'b0;
   localparam logic OP_VALUE = 1'b1;

   // response kinds
   localparam logic [KIND_WIDTH-1:0] KIND_PROBE = 2'd0;
   localparam logic [KIND_WIDTH-1:0] KIND_DONE  = 2'd1;
   localparam logic [KIND_WIDTH-1:0] KIND_ERROR = 2'd2;

   // search phases
   localparam logic [PHASE_WIDTH-1:0] PH_IDLE       = 3'd0;
   localparam logic [PHASE_WIDTH-1:0] PH_WAIT_C     = 3'd1;
   localparam logic [PHASE_WIDTH-1:0] PH_WAIT_D     = 3'd2;
   localparam logic [PHASE_WIDTH-1:0] PH_WAIT_NEW_C = 3'd3;
   localparam logic [PHASE_WIDTH-1:0] PH_WAIT_NEW_D = 3'd4;

endpackage

FILE: rtl/gsm_probe.sv
// inner point generator: span times 1/phi, offset from a base, clamped to the bounds
`timescale 1ns / 1ps

module gsm_probe #(
   parameter int POS_WIDTH = gsm_pkg::POS_WIDTH_DEFAULT
) (
   input  logic        [POS_WIDTH-1:0] diff,
   input  logic signed [POS_WIDTH-1:0] hi_base,
   input  logic signed [POS_WIDTH-1:0] lo_base,
   input  logic signed [POS_WIDTH-1:0] bound_low,
   input  logic signed [POS_WIDTH-1:0] bound_high,
   output logic signed [POS_WIDTH-1:0] probe_left,
   output logic signed [POS_WIDTH-1:0] probe_right
);
   import gsm_pkg::*;

   localparam int PROD_WIDTH = POS_WIDTH + INV_PHI_BITS;
   localparam int RAW_WIDTH  = POS_WIDTH + 2;

   logic        [PROD_WIDTH-1:0] prod;
   logic        [POS_WIDTH-1:0]  step;
   logic signed [RAW_WIDTH-1:0]  left_raw;
   logic signed [RAW_WIDTH-1:0]  right_raw;
   logic signed [RAW_WIDTH-1:0]  low_ext;
   logic signed [RAW_WIDTH-1:0]  high_ext;

   function automatic logic signed [POS_WIDTH-1:0] clamp(
      input logic signed [RAW_WIDTH-1:0] v,
      input logic signed [RAW_WIDTH-1:0] lo,
      input logic signed [RAW_WIDTH-1:0] hi
   );
      logic signed [RAW_WIDTH-1:0] r;
      if (v < lo) begin
         r = lo;
      end else if (hi < v) begin
         r = hi;
      end else begin
         r = v;
      end
      return r[POS_WIDTH-1:0];
   endfunction

   // exact floor(diff * INV_PHI / 2^16), with 1/phi held to 16 fraction bits
   assign prod = PROD_WIDTH'(diff) * PROD_WIDTH'(INV_PHI);
   assign step = prod[PROD_WIDTH-1:INV_PHI_BITS];

   assign left_raw  = RAW_WIDTH'(hi_base) - RAW_WIDTH'(step);
   assign right_raw = RAW_WIDTH'(lo_base) + RAW_WIDTH'(step);
   assign low_ext   = RAW_WIDTH'(bound_low);
   assign high_ext  = RAW_WIDTH'(bound_high);

   assign probe_left  = clamp(left_raw, low_ext, high_ext);
   assign probe_right = clamp(right_raw, low_ext, high_ext);

endmodule

FILE: rtl/golden_section_minimizer.sv
// golden-section minimizer, top level
// usage:
//  - req channel (valid/stall): op start brings the two ends, op value brings f at the
//    last probed point; a transfer happens when req_valid is high and req_stall low
//  - rsp channel (valid/stall): one response per request, kind probe (point to evaluate),
//    done (minimum estimate) or error (value with no search running, point zero)
//  - csr channel (valid/ready): writes the stop tolerance, always ready; write only
//    while no request is in flight
//  - a transferred request is registered in the input stage, then worked out into the
//    response register once that slot is free; rsp shows the registered response
//  - throughput: one request per cycle while rsp_stall stays low; the search state loop
//    (one 32x16 multiply, a clamp and the stop compare) is purely combinational
//  - a stalled response holds; one more request can be taken in the input stage,
//    after that req_stall rises until the response transfers
//  - reset (synchronous, active high) drops any search, empties both stages and
//    restores the tolerance to its default
`timescale 1ns / 1ps

module golden_section_minimizer #(
   parameter int POS_WIDTH = gsm_pkg::POS_WIDTH_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic                                  req_op,
   input  logic signed [gsm_pkg::FIELD_WIDTH-1:0] req_low_end,
   input  logic signed [gsm_pkg::FIELD_WIDTH-1:0] req_high_end,
   input  logic signed [gsm_pkg::FIELD_WIDTH-1:0] req_fvalue,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic        [gsm_pkg::KIND_WIDTH-1:0]  rsp_kind,
   output logic signed [gsm_pkg::FIELD_WIDTH-1:0] rsp_point,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic        [gsm_pkg::TOL_WIDTH-1:0]   csr_tolerance
);
   import gsm_pkg::*;

   // width big enough for both a position and a port field
   localparam int EXT_WIDTH = (POS_WIDTH > FIELD_WIDTH) ? POS_WIDTH : FIELD_WIDTH;
   // width for the stop compare
   localparam int CMP_WIDTH = (POS_WIDTH > TOL_WIDTH) ? POS_WIDTH : TOL_WIDTH;

   // ---------------------------------------------------------------- helpers

   // distance between two positions, always non-negative
   function automatic logic [POS_WIDTH-1:0] gap(
      input logic signed [POS_WIDTH-1:0] x,
      input logic signed [POS_WIDTH-1:0] y
   );
      logic [POS_WIDTH-1:0] r;
      if (x < y) begin
         r = y - x;
      end else begin
         r = x - y;
      end
      return r;
   endfunction

   // interval length, zero when the ends have crossed
   function automatic logic [POS_WIDTH-1:0] span(
      input logic signed [POS_WIDTH-1:0] hi,
      input logic signed [POS_WIDTH-1:0] lo
   );
      logic [POS_WIDTH-1:0] r;
      if (hi < lo) begin
         r = '0;
      end else begin
         r = hi - lo;
      end
      return r;
   endfunction

   // floor of the midpoint, taken from the lower point
   function automatic logic signed [POS_WIDTH-1:0] mid(
      input logic signed [POS_WIDTH-1:0] x,
      input logic signed [POS_WIDTH-1:0] y
   );
      logic signed [POS_WIDTH-1:0] lo;
      lo = (y < x) ? y : x;
      return lo + (gap(x, y) >> 1);
   endfunction

   // ---------------------------------------------------------------- signals

   // input stage
   logic                         s1_valid_ff, s1_valid_in;
   logic                         s1_op_ff;
   logic signed [FIELD_WIDTH-1:0] s1_low_ff, s1_high_ff, s1_fvalue_ff;
   logic                         accept;
   logic                         out_free;
   logic                         go;

   // configuration
   logic [TOL_WIDTH-1:0] tolerance_ff;

   // search state
   logic [PHASE_WIDTH-1:0]      phase_ff, phase_in;
   logic signed [POS_WIDTH-1:0] left_end_ff, left_end_in;
   logic signed [POS_WIDTH-1:0] right_end_ff, right_end_in;
   logic signed [POS_WIDTH-1:0] inner_left_ff, inner_left_in;
   logic signed [POS_WIDTH-1:0] inner_right_ff, inner_right_in;
   logic signed [POS_WIDTH-1:0] bound_low_ff, bound_low_in;
   logic signed [POS_WIDTH-1:0] bound_high_ff, bound_high_in;
   logic signed [FIELD_WIDTH-1:0] value_left_ff, value_left_in;
   logic signed [FIELD_WIDTH-1:0] value_right_ff, value_right_in;

   // response register
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [KIND_WIDTH-1:0]       rsp_kind_ff, rsp_kind_in;
   logic signed [POS_WIDTH-1:0] rsp_point_ff, rsp_point_in;
   logic signed [EXT_WIDTH-1:0] point_ext;

   // start decode
   logic signed [EXT_WIDTH-1:0] low_ext, high_ext;
   logic signed [POS_WIDTH-1:0] pos_low, pos_high;
   logic signed [POS_WIDTH-1:0] sort_lo, sort_hi;
   logic                        is_start;

   // narrowing
   logic signed [FIELD_WIDTH-1:0] val_left_eff, val_right_eff;
   logic                          keep_left;
   logic signed [POS_WIDTH-1:0]   nar_c, nar_d;
   logic                          nar_close, cur_close;
   logic                          do_narrow;

   // probe unit hookup
   logic        [POS_WIDTH-1:0] pr_diff;
   logic signed [POS_WIDTH-1:0] pr_hi_base, pr_lo_base, pr_bound_low, pr_bound_high;
   logic signed [POS_WIDTH-1:0] probe_left, probe_right;

   // ---------------------------------------------------------------- handshakes

   // the response slot frees up when empty or being taken this cycle
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign go        = s1_valid_ff && out_free;
   assign req_stall = s1_valid_ff && !out_free;
   assign accept    = req_valid && !req_stall;
   assign csr_ready = 1'b1;

   assign s1_valid_in  = accept ? 1'b1 : (go ? 1'b0 : s1_valid_ff);
   assign rsp_valid_in = go ? 1'b1 : (rsp_stall ? rsp_valid_ff : 1'b0);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         phase_ff     <= PH_IDLE;
         tolerance_ff <= TOL_RESET;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (go) begin
            phase_ff <= phase_in;
         end
         if (csr_valid && csr_ready) begin
            tolerance_ff <= csr_tolerance;
         end
      end
   end

   // input stage payload
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_op_ff     <= req_op;
         s1_low_ff    <= req_low_end;
         s1_high_ff   <= req_high_end;
         s1_fvalue_ff <= req_fvalue;
      end
   end

   // search data and response payload move only when a request is worked out
   always_ff @(posedge clock) begin
      if (go) begin
         left_end_ff    <= left_end_in;
         right_end_ff   <= right_end_in;
         inner_left_ff  <= inner_left_in;
         inner_right_ff <= inner_right_in;
         bound_low_ff   <= bound_low_in;
         bound_high_ff  <= bound_high_in;
         value_left_ff  <= value_left_in;
         value_right_ff <= value_right_in;
         rsp_kind_ff    <= rsp_kind_in;
         rsp_point_ff   <= rsp_point_in;
      end
   end

   // ---------------------------------------------------------------- datapath

   // port fields to position width
   assign low_ext  = EXT_WIDTH'(s1_low_ff);
   assign high_ext = EXT_WIDTH'(s1_high_ff);
   assign pos_low  = low_ext[POS_WIDTH-1:0];
   assign pos_high = high_ext[POS_WIDTH-1:0];
   assign is_start = (s1_op_ff == OP_START);

   // reversed ends get sorted before anything else
   assign sort_lo = (pos_high < pos_low) ? pos_high : pos_low;
   assign sort_hi = (pos_high < pos_low) ? pos_low : pos_high;

   // the fresh value replaces the stored one for the point it belongs to
   assign val_left_eff  = (phase_ff == PH_WAIT_C || phase_ff == PH_WAIT_NEW_C) ?
                          s1_fvalue_ff : value_left_ff;
   assign val_right_eff = (phase_ff == PH_WAIT_D || phase_ff == PH_WAIT_NEW_D) ?
                          s1_fvalue_ff : value_right_ff;

   // ties keep the right side
   assign keep_left = (val_left_eff < val_right_eff);

   // one probe unit serves both the start and each narrowing step
   always_comb begin
      if (is_start) begin
         pr_diff       = span(sort_hi, sort_lo);
         pr_hi_base    = sort_hi;
         pr_lo_base    = sort_lo;
         pr_bound_low  = sort_lo;
         pr_bound_high = sort_hi;
      end else begin
         pr_diff       = keep_left ? span(inner_right_ff, left_end_ff)
                                   : span(right_end_ff, inner_left_ff);
         pr_hi_base    = inner_right_ff;
         pr_lo_base    = inner_left_ff;
         pr_bound_low  = bound_low_ff;
         pr_bound_high = bound_high_ff;
      end
   end

   gsm_probe #(
      .POS_WIDTH (POS_WIDTH)
   ) u_probe (
      .diff        (pr_diff),
      .hi_base     (pr_hi_base),
      .lo_base     (pr_lo_base),
      .bound_low   (pr_bound_low),
      .bound_high  (pr_bound_high),
      .probe_left  (probe_left),
      .probe_right (probe_right)
   );

   // inner points after a narrowing step
   assign nar_c = keep_left ? probe_left : inner_right_ff;
   assign nar_d = keep_left ? inner_left_ff : probe_right;

   assign cur_close = CMP_WIDTH'(gap(inner_left_ff, inner_right_ff)) <=
                      CMP_WIDTH'(tolerance_ff);
   assign nar_close = CMP_WIDTH'(gap(nar_c, nar_d)) <= CMP_WIDTH'(tolerance_ff);

   // ---------------------------------------------------------------- search control

   always_comb begin
      phase_in       = phase_ff;
      left_end_in    = left_end_ff;
      right_end_in   = right_end_ff;
      inner_left_in  = inner_left_ff;
      inner_right_in = inner_right_ff;
      bound_low_in   = bound_low_ff;
      bound_high_in  = bound_high_ff;
      value_left_in  = value_left_ff;
      value_right_in = value_right_ff;
      rsp_kind_in    = KIND_PROBE;
      rsp_point_in   = '0;
      do_narrow      = 1'b0;

      if (is_start) begin
         if (pos_low == pos_high) begin
            // empty interval: answer at once
            phase_in     = PH_IDLE;
            rsp_kind_in  = KIND_DONE;
            rsp_point_in = pos_low;
         end else begin
            left_end_in    = sort_lo;
            right_end_in   = sort_hi;
            bound_low_in   = sort_lo;
            bound_high_in  = sort_hi;
            inner_left_in  = probe_left;
            inner_right_in = probe_right;
            phase_in       = PH_WAIT_C;
            rsp_point_in   = probe_left;
         end
      end else begin
         unique case (phase_ff)
            PH_WAIT_C: begin
               value_left_in = s1_fvalue_ff;
               phase_in      = PH_WAIT_D;
               rsp_point_in  = inner_right_ff;
            end
            PH_WAIT_D: begin
               value_right_in = s1_fvalue_ff;
               if (cur_close) begin
                  phase_in     = PH_IDLE;
                  rsp_kind_in  = KIND_DONE;
                  rsp_point_in = mid(inner_left_ff, inner_right_ff);
               end else begin
                  do_narrow = 1'b1;
               end
            end
            PH_WAIT_NEW_C: begin
               value_left_in = s1_fvalue_ff;
               do_narrow     = 1'b1;
            end
            PH_WAIT_NEW_D: begin
               value_right_in = s1_fvalue_ff;
               do_narrow      = 1'b1;
            end
            default: begin
               // value with no search running
               phase_in     = PH_IDLE;
               rsp_kind_in  = KIND_ERROR;
               rsp_point_in = '0;
            end
         endcase
      end

      if (do_narrow) begin
         inner_left_in  = nar_c;
         inner_right_in = nar_d;
         if (keep_left) begin
            right_end_in   = inner_right_ff;
            value_right_in = val_left_eff;
         end else begin
            left_end_in   = inner_left_ff;
            value_left_in = val_right_eff;
         end
         if (nar_close) begin
            phase_in     = PH_IDLE;
            rsp_kind_in  = KIND_DONE;
            rsp_point_in = mid(nar_c, nar_d);
         end else if (keep_left) begin
            phase_in     = PH_WAIT_NEW_C;
            rsp_point_in = probe_left;
         end else begin
            phase_in     = PH_WAIT_NEW_D;
            rsp_point_in = probe_right;
         end
      end
   end

   // ---------------------------------------------------------------- outputs

   assign point_ext = EXT_WIDTH'(rsp_point_ff);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_kind  = rsp_kind_ff;
   assign rsp_point = point_ext[FIELD_WIDTH-1:0];

   // ---------------------------------------------------------------- checks

`ifndef SYNTHESIS
   // a running search always has a proper, sorted interval
   a_bounds_sorted: assert property (@(posedge clock) disable iff (reset)
      (phase_ff != PH_IDLE) |-> (bound_low_ff < bound_high_ff))
      else $error("search running with unsorted bounds");

   // every probe handed out lies between the clamp bounds
   a_probe_in_bounds: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_kind_ff == KIND_PROBE) |->
      (bound_low_ff <= rsp_point_ff && rsp_point_ff <= bound_high_ff))
      else $error("probe outside the search bounds");

   // a done or error response leaves the search idle
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_kind_ff == KIND_DONE || rsp_kind_ff == KIND_ERROR)) |->
      (phase_ff == PH_IDLE))
      else $error("search still running after done or error");

   // a worked-out request always lands in the response register
   a_go_responds: assert property (@(posedge clock) disable iff (reset)
      go |=> rsp_valid_ff)
      else $error("request worked out without a response");
`endif

endmodule

FILE: dv/golden_section_minimizer_tb.sv
// self-checking testbench for the golden-section minimizer
`timescale 1ns / 1ps

module golden_section_minimizer_tb;
   import gsm_pkg::*;

   localparam int CLOCK_HALF    = 6;
   localparam int RESET_CYCLES  = 10;
   localparam int SEGMENTS      = 6;
   localparam int SEGMENT_ITEMS = 200;
   localparam int DRAIN_HOLD    = 4;     // extra edges waited after the last awaited response
   localparam int WATCHDOG      = 2000;  // cycles with no transfer on any channel
   localparam int MAX_REPORTS   = 10;
   localparam int SEARCH_BUDGET = 60;    // value items before a search is abandoned

   logic                           clock;
   logic                           reset         = 1'b1;
   logic                           req_valid     = 1'b0;
   logic                           req_stall;
   logic                           req_op        = OP_START;
   logic signed [FIELD_WIDTH-1:0]  req_low_end   = '0;
   logic signed [FIELD_WIDTH-1:0]  req_high_end  = '0;
   logic signed [FIELD_WIDTH-1:0]  req_fvalue    = '0;
   logic                           rsp_valid;
   logic                           rsp_stall     = 1'b0;
   logic        [KIND_WIDTH-1:0]   rsp_kind;
   logic signed [FIELD_WIDTH-1:0]  rsp_point;
   logic                           csr_valid     = 1'b0;
   logic                           csr_ready;
   logic        [TOL_WIDTH-1:0]    csr_tolerance = '0;

   int sender_idle_pct    = 0;
   int receiver_stall_pct = 0;
   int requests_sent      = 0;

   golden_section_minimizer dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_op        (req_op),
      .req_low_end   (req_low_end),
      .req_high_end  (req_high_end),
      .req_fvalue    (req_fvalue),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_kind      (rsp_kind),
      .rsp_point     (rsp_point),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_tolerance (csr_tolerance)
   );

   // tracks the search the block should be running and the responses it owes;
   // positions are held sign extended to 64 bits so no step can overflow
   class search_tracker;
      longint tolerance;
      longint left_end, right_end, inner_c, inner_d, f_c, f_d, bound_lo, bound_hi;
      logic [PHASE_WIDTH-1:0]        search_phase;
      logic [KIND_WIDTH-1:0]         awaited_kind[$];
      logic [FIELD_WIDTH-1:0]        awaited_point[$];
      logic [KIND_WIDTH-1:0]         last_kind;
      logic signed [FIELD_WIDTH-1:0] last_point;
      int mismatches;
      int responses;

      function new();
         tolerance    = longint'(TOL_RESET);
         left_end     = 0;
         right_end    = 0;
         inner_c      = 0;
         inner_d      = 0;
         f_c          = 0;
         f_d          = 0;
         bound_lo     = 0;
         bound_hi     = 0;
         search_phase = PH_IDLE;
         last_kind    = KIND_ERROR;
         last_point   = '0;
         mismatches   = 0;
         responses    = 0;
      endfunction

      function int pending();
         return awaited_kind.size();
      endfunction

      function void queue_result(logic [KIND_WIDTH-1:0] kind, longint pt);
         awaited_kind.push_back(kind);
         awaited_point.push_back(pt[FIELD_WIDTH-1:0]);
         last_kind  = kind;
         last_point = pt[FIELD_WIDTH-1:0];
      endfunction

      // floor(width * INV_PHI / 2^16), exact in two partial products
      function longint golden_cut(longint width);
         longint k;
         k = longint'(INV_PHI);
         return (width >>> INV_PHI_BITS) * k + (((width & 64'hFFFF) * k) >>> INV_PHI_BITS);
      endfunction

      function longint interval_width();
         return (right_end < left_end) ? 0 : right_end - left_end;
      endfunction

      // clamp against the sorted start ends
      function longint clamp(longint v);
         if (v < bound_lo) return bound_lo;
         if (v > bound_hi) return bound_hi;
         return v;
      endfunction

      function bit converged();
         longint gap;
         gap = inner_d - inner_c;
         if (gap < 0) gap = -gap;
         return gap <= tolerance;
      endfunction

      function void conclude();
         longint lo, hi;
         lo = (inner_c < inner_d) ? inner_c : inner_d;
         hi = (inner_c < inner_d) ? inner_d : inner_c;
         search_phase = PH_IDLE;
         queue_result(KIND_DONE, lo + ((hi - lo) >>> 1));
      endfunction

      // keep the side with the smaller value, ties keep the right side
      function void narrow();
         if (f_c < f_d) begin
            right_end = inner_d;
            inner_d   = inner_c;
            f_d       = f_c;
            inner_c   = clamp(right_end - golden_cut(interval_width()));
            if (converged()) begin
               conclude();
            end else begin
               search_phase = PH_WAIT_NEW_C;
               queue_result(KIND_PROBE, inner_c);
            end
         end else begin
            left_end = inner_c;
            inner_c  = inner_d;
            f_c      = f_d;
            inner_d  = clamp(left_end + golden_cut(interval_width()));
            if (converged()) begin
               conclude();
            end else begin
               search_phase = PH_WAIT_NEW_D;
               queue_result(KIND_PROBE, inner_d);
            end
         end
      endfunction

      function void take_request(logic op, logic signed [FIELD_WIDTH-1:0] lo_in,
                                 logic signed [FIELD_WIDTH-1:0] hi_in,
                                 logic signed [FIELD_WIDTH-1:0] fv);
         longint a, b, t;
         a = longint'(lo_in);
         b = longint'(hi_in);
         if (op == OP_START) begin
            if (a == b) begin
               search_phase = PH_IDLE;
               queue_result(KIND_DONE, a);
               return;
            end
            if (b < a) begin
               t = a;
               a = b;
               b = t;
            end
            left_end     = a;
            right_end    = b;
            bound_lo     = a;
            bound_hi     = b;
            t            = golden_cut(b - a);
            inner_c      = clamp(b - t);
            inner_d      = clamp(a + t);
            search_phase = PH_WAIT_C;
            queue_result(KIND_PROBE, inner_c);
            return;
         end
         case (search_phase)
            PH_WAIT_C: begin
               f_c          = longint'(fv);
               search_phase = PH_WAIT_D;
               queue_result(KIND_PROBE, inner_d);
            end
            PH_WAIT_D: begin
               f_d = longint'(fv);
               if (converged()) conclude();
               else narrow();
            end
            PH_WAIT_NEW_C: begin
               f_c = longint'(fv);
               narrow();
            end
            PH_WAIT_NEW_D: begin
               f_d = longint'(fv);
               narrow();
            end
            default: begin
               search_phase = PH_IDLE;
               queue_result(KIND_ERROR, 64'sd0);
            end
         endcase
      endfunction

      function void check_response(logic [KIND_WIDTH-1:0] kind, logic [FIELD_WIDTH-1:0] point);
         logic [KIND_WIDTH-1:0]  want_kind;
         logic [FIELD_WIDTH-1:0] want_point;
         responses++;
         if (awaited_kind.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("response %0d: none awaited, got kind %0d point %h",
                        responses, kind, point);
            return;
         end
         want_kind  = awaited_kind.pop_front();
         want_point = awaited_point.pop_front();
         if (kind !== want_kind || point !== want_point) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("response %0d: kind exp %0d got %0d, point exp %h got %h",
                        responses, want_kind, kind, want_point, point);
         end
      endfunction
   endclass

   search_tracker tracker = new();

   initial begin
      clock = 1'b0;
      forever #CLOCK_HALF clock = ~clock;
   end

   // receiver side: random stall, redrawn every cycle
   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < receiver_stall_pct);
   end

   // response transfers, sampled at the edge so the order within the step does not matter
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         tracker.check_response(rsp_kind, rsp_point);
   end

   // watchdog: ends the run once no channel has moved for too long
   initial begin
      int quiet;
      quiet = 0;
      while (quiet < WATCHDOG) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready))
            quiet = 0;
         else
            quiet++;
      end
      $display("end of test: mismatches");
      $finish;
   end

   // one request transfer; the payload holds while stalled and the transfer is
   // noted at its edge, before the next item is built from the latest prediction
   task automatic send_request(input logic op, input logic signed [FIELD_WIDTH-1:0] lo,
                               input logic signed [FIELD_WIDTH-1:0] hi,
                               input logic signed [FIELD_WIDTH-1:0] fv);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_op       <= op;
      req_low_end  <= lo;
      req_high_end <= hi;
      req_fvalue   <= fv;
      do @(posedge clock); while (req_stall);
      tracker.take_request(op, lo, hi, fv);
      requests_sent++;
   endtask

   // sender holds off until every awaited response has arrived; the first edge is
   // skipped so the transfer noted at the current edge is already counted
   task automatic wait_for_drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (tracker.pending() != 0);
      repeat (DRAIN_HOLD) @(posedge clock);
   endtask

   task automatic write_tolerance(input logic [TOL_WIDTH-1:0] value);
      wait_for_drain();
      csr_valid     <= 1'b1;
      csr_tolerance <= value;
      do @(posedge clock); while (!csr_ready);
      tracker.tolerance = longint'(value);
      csr_valid <= 1'b0;
   endtask

   // start a search and answer every probe from a chosen objective shape:
   // 0 valley at target, 1 peak at target, 2 flat (ties), 3 noise, 4 coarse valley
   task automatic run_search(input logic signed [FIELD_WIDTH-1:0] lo,
                             input logic signed [FIELD_WIDTH-1:0] hi,
                             input int shape, input int budget);
      longint target, v;
      int     values;
      target = longint'(lo) + (longint'(hi) - longint'(lo))
               * longint'($urandom_range(0, 1000)) / 64'sd1000;
      send_request(OP_START, lo, hi, $urandom);
      values = 0;
      while (tracker.last_kind == KIND_PROBE && values < budget) begin
         v = longint'(tracker.last_point) - target;
         if (v < 0) v = -v;
         case (shape)
            0: ;
            1: v = -v;
            2: v = 64'sd777;
            3: v = longint'(int'($urandom));
            default: v = v >>> 12;
         endcase
         if (v > 64'sd2147483647) v = 64'sd2147483647;
         if (v < -64'sd2147483648) v = -64'sd2147483648;
         send_request(OP_VALUE, $urandom, $urandom, v[FIELD_WIDTH-1:0]);
         values++;
      end
   endtask

   initial begin
      int                            segment_end, pick, shape, budget;
      logic [TOL_WIDTH-1:0]          tol_value;
      logic signed [FIELD_WIDTH-1:0] lo, hi, swap_tmp;

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      sender_idle_pct    = 9;
      receiver_stall_pct = 56;

      // directed part, default tolerance
      // value with no search running
      send_request(OP_VALUE, 32'sh7FFFFFFF, 32'sh80000000, 32'sh80000000);
      // equal ends at both extremes finish at once
      send_request(OP_START, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF);
      send_request(OP_START, 32'sh80000000, 32'sh80000000, '0);
      // widest interval, left value smaller keeps the left side
      send_request(OP_START, 32'sh80000000, 32'sh7FFFFFFF, '0);
      send_request(OP_VALUE, '0, '0, 32'sh80000000);
      send_request(OP_VALUE, '0, '0, 32'sh7FFFFFFF);
      send_request(OP_VALUE, 32'shFFFFFFFF, 32'shFFFFFFFF, '0);
      // restart mid search with reversed widest ends, then a tie keeps the right side
      send_request(OP_START, 32'sh7FFFFFFF, 32'sh80000000, 32'shFFFFFFFF);
      send_request(OP_VALUE, '0, '0, 32'sd5);
      send_request(OP_VALUE, '0, '0, 32'sd5);
      send_request(OP_VALUE, '0, '0, -32'sd7);
      // inner points already within tolerance: both values still asked, then done; a third value errors
      send_request(OP_START, '0, 32'sd100, '0);
      send_request(OP_VALUE, '0, '0, 32'sd3);
      send_request(OP_VALUE, '0, '0, 32'sd1);
      send_request(OP_VALUE, '0, '0, '0);
      // reversed negative ends
      run_search(-32'sd100000, -32'sd300000, 0, 6);
      // zero tolerance on the smallest interval may probe forever
      write_tolerance('0);
      run_search('0, 32'sd1, 0, 6);

      // random part: idling pattern changes every two segments, tolerance every segment
      for (int seg = 0; seg < SEGMENTS; seg++) begin
         case (seg / 2)
            0: begin
               sender_idle_pct    = 9;
               receiver_stall_pct = 56;
            end
            1: begin
               sender_idle_pct    = 56;
               receiver_stall_pct = 9;
            end
            default: begin
               sender_idle_pct    = 0;
               receiver_stall_pct = 0;
            end
         endcase
         case (seg)
            0:       tol_value = TOL_WIDTH'($urandom_range(0, 4096));
            1:       tol_value = '0;
            2:       tol_value = '1;
            3:       tol_value = TOL_WIDTH'($urandom);
            4:       tol_value = TOL_RESET;
            default: tol_value = TOL_WIDTH'($urandom_range(1, 1 << 20));
         endcase
         write_tolerance(tol_value);

         segment_end = requests_sent + SEGMENT_ITEMS;
         while (requests_sent < segment_end) begin
            pick = $urandom_range(9);
            case (pick)
               0, 1, 2: begin
                  lo = $urandom;
                  hi = $urandom;
               end
               3, 4, 5: begin
                  lo = $urandom;
                  hi = lo + $urandom_range(1, 2000);
               end
               6: begin
                  lo = $urandom;
                  hi = lo;
               end
               7: begin
                  lo = 32'sh80000000 + $urandom_range(0, 255);
                  hi = 32'sh7FFFFFFF - $urandom_range(0, 255);
               end
               default: begin
                  lo = $urandom_range(0, 1 << 20) - (1 << 19);
                  hi = lo + $urandom_range(1 << 16, 1 << 24);
               end
            endcase
            if ($urandom_range(1)) begin
               swap_tmp = lo;
               lo       = hi;
               hi       = swap_tmp;
            end
            shape = $urandom_range(4);
            // some searches are cut short so the next start lands mid search
            budget = ($urandom_range(99) < 15) ? $urandom_range(0, 5) : SEARCH_BUDGET;
            run_search(lo, hi, shape, budget);
            // stray value item, usually after a finished search
            if ($urandom_range(99) < 8)
               send_request(OP_VALUE, $urandom, $urandom, $urandom);
         end
      end

      wait_for_drain();
      if (tracker.mismatches == 0 && tracker.pending() == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule

FILE: golden_section_minimizer.f
rtl/gsm_pkg.sv
rtl/gsm_probe.sv
rtl/golden_section_minimizer.sv
dv/golden_section_minimizer_tb.sv
